FILE: rtl/core/tncs_pkg.sv
// Shared types and constants for the telnet receive command stripper.
// Depends on nothing; imported by the parser, the core and the checker.
package tncs_pkg;

  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_SE   = 8'd240;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] LIT_FF   = 8'hff;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam logic [2:0] SUBNEG_MAX  = 3'd7;
  localparam logic [2:0] SUBNEG_NAWS = 3'd5;  // option byte plus four value bytes

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_NAWS = 1'b1;

  localparam int RESULT_W = 40;  // tdata: data_byte, columns, rows

  typedef enum logic [5:0] {
    PH_TEXT   = 6'b000001,
    PH_CR     = 6'b000010,
    PH_IAC    = 6'b000100,
    PH_OPT    = 6'b001000,
    PH_SUB    = 6'b010000,
    PH_SUBIAC = 6'b100000
  } phase_t;

  // Up to two results per request; the second is always a data byte.
  typedef struct packed {
    logic        two;
    logic        r0_kind;
    logic [7:0]  r0_byte;
    logic [15:0] r0_cols;
    logic [15:0] r0_rows;
    logic [7:0]  r1_byte;
  } entry_t;

  typedef struct packed {
    logic [1:0] cnt;
    entry_t     entry;
  } step_t;

endpackage

FILE: rtl/core/telnet_receive_command_stripper_core.sv
// Telnet receive command stripper: strips commands, normalises line ends
// and reports NAWS window sizes. Each result is registered in the result
// queue before it shows on m_*. Throughput: one request per cycle while
// results drain; a request giving two results shows them one after the other.
// Reset (rst, synchronous, high) returns the parser to text and empties
// the two-entry result queue. Depends on tncs_pkg and tncs_parser.
module telnet_receive_command_stripper_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  input  logic                          s_tlast,   // end_of_segment
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tncs_pkg::RESULT_W-1:0] m_tdata,   // [7:0] data_byte, [23:8] columns,
                                                   // [39:24] rows
  output logic                          m_tuser,   // kind
  output logic                          m_tlast    // last result of its request
);
  import tncs_pkg::*;

  step_t  step;
  logic   take;

  // Result queue: one entry per request that gives results, holding all of them.
  entry_t     queue [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       sub;          // which result of the head entry is shown
  entry_t     head;
  logic       push, pop_res, entry_done;

  // queue has room for a whole request as long as one slot is free
  assign s_tready = (count != 2'd2);
  assign take     = s_tvalid & s_tready;

  tncs_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .in_byte        (s_tdata),
    .end_of_segment (s_tlast),
    .step           (step)
  );

  assign push       = take & (step.cnt != 2'd0);
  assign head       = queue[rd_ptr];
  assign m_tvalid   = (count != 2'd0);
  assign pop_res    = m_tvalid & m_tready;
  assign entry_done = pop_res & (sub | ~head.two);

  // Output view of the head: second result is always a plain data byte.
  always_comb begin
    if (sub) begin
      m_tuser = KIND_DATA;
      m_tdata = {32'd0, head.r1_byte};
      m_tlast = 1'b1;
    end else begin
      m_tuser = head.r0_kind;
      m_tdata = {head.r0_rows, head.r0_cols, head.r0_byte};
      m_tlast = ~head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= step.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (entry_done) rd_ptr <= ~rd_ptr;
      if (pop_res) sub <= ~entry_done;
      count <= count + {1'b0, push} - {1'b0, entry_done};
    end
  end

endmodule

FILE: rtl/core/tncs_parser.sv
// Telnet receive parser: phase register, subnegotiation holds and the
// single-pass next-state and result logic. Depends on tncs_pkg.
module tncs_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     in_byte,
  input  logic           end_of_segment,
  output tncs_pkg::step_t step
);
  import tncs_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  subneg_count, subneg_count_next;
  logic [7:0]  subneg_option, subneg_option_next;
  logic [15:0] width_hold, width_hold_next;
  logic [15:0] height_hold, height_hold_next;

  logic        sub_take;  // byte goes into the subnegotiation holds
  logic        txt_take;  // byte handled as plain text
  logic        emit_lf0;  // LF for a CR ahead of the byte

  always_comb begin
    phase_next         = phase;
    subneg_count_next  = subneg_count;
    subneg_option_next = subneg_option;
    width_hold_next    = width_hold;
    height_hold_next   = height_hold;
    step               = '0;
    sub_take           = 1'b0;
    txt_take           = 1'b0;
    emit_lf0           = 1'b0;

    case (phase)
      PH_CR: begin
        if (in_byte == CH_NUL) begin
          phase_next = PH_TEXT;
          step.cnt = 2'd1;
          step.entry.r0_byte = CH_CR;
        end else if (in_byte == CH_LF) begin
          phase_next = PH_TEXT;
          step.cnt = 2'd1;
          step.entry.r0_byte = CH_LF;
        end else begin
          emit_lf0 = 1'b1;
          txt_take = 1'b1;
        end
      end
      PH_IAC: begin
        if (in_byte == CMD_IAC) begin
          phase_next = PH_TEXT;
          step.cnt = 2'd1;
          step.entry.r0_byte = LIT_FF;
        end else if (in_byte inside {[CMD_WILL:CMD_DONT]}) begin
          phase_next = PH_OPT;
        end else if (in_byte == CMD_SB) begin
          phase_next         = PH_SUB;
          subneg_count_next  = '0;
          subneg_option_next = '0;
          width_hold_next    = '0;
          height_hold_next   = '0;
        end else begin
          phase_next = PH_TEXT;
        end
      end
      PH_OPT: phase_next = PH_TEXT;
      PH_SUB: begin
        if (in_byte == CMD_IAC) phase_next = PH_SUBIAC;
        else sub_take = 1'b1;
      end
      PH_SUBIAC: begin
        if (in_byte == CMD_SE) begin
          phase_next = PH_TEXT;
          if (subneg_option == OPT_NAWS && subneg_count >= SUBNEG_NAWS) begin
            step.cnt = 2'd1;
            step.entry.r0_kind = KIND_NAWS;
            step.entry.r0_cols = width_hold;
            step.entry.r0_rows = height_hold;
          end
        end else begin
          phase_next = PH_SUB;
          sub_take = 1'b1;
        end
      end
      default: txt_take = 1'b1;
    endcase

    if (emit_lf0) begin
      step.cnt = 2'd1;
      step.entry.r0_byte = CH_LF;
    end

    if (txt_take) begin
      if (in_byte == CMD_IAC) begin
        phase_next = PH_IAC;
      end else if (in_byte == CH_CR) begin
        phase_next = PH_CR;
      end else begin
        phase_next = PH_TEXT;
        if (emit_lf0) begin
          step.cnt = 2'd2;
          step.entry.two = 1'b1;
          step.entry.r1_byte = in_byte;
        end else begin
          step.cnt = 2'd1;
          step.entry.r0_byte = in_byte;
        end
      end
    end

    if (sub_take) begin
      case (subneg_count)
        3'd0: subneg_option_next = in_byte;
        3'd1: width_hold_next[15:8] = in_byte;
        3'd2: width_hold_next[7:0] = in_byte;
        3'd3: height_hold_next[15:8] = in_byte;
        3'd4: height_hold_next[7:0] = in_byte;
        default: ;
      endcase
      if (subneg_count != SUBNEG_MAX) subneg_count_next = subneg_count + 3'd1;
    end

    // segment end: flush a pending CR, drop any unfinished command
    if (end_of_segment) begin
      if (phase_next == PH_CR) begin
        if (step.cnt == 2'd0) begin
          step.entry.r0_byte = CH_LF;
        end else begin
          step.entry.two = 1'b1;
          step.entry.r1_byte = CH_LF;
        end
        step.cnt = step.cnt + 2'd1;
      end
      phase_next = PH_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TEXT;
      subneg_count  <= '0;
      subneg_option <= '0;
      width_hold    <= '0;
      height_hold   <= '0;
    end else if (take) begin
      phase         <= phase_next;
      subneg_count  <= subneg_count_next;
      subneg_option <= subneg_option_next;
      width_hold    <= width_hold_next;
      height_hold   <= height_hold_next;
    end
  end

endmodule

FILE: rtl/core/tncs_checker.sv
// Port-level checker for the telnet receive command stripper core, with
// its bind. Depends on tncs_pkg and telnet_receive_command_stripper_core.
module tncs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tncs_pkg::RESULT_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);
  import tncs_pkg::*;

  // results wait until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

  // a window size update is always the only result of its request
  a_naws_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_NAWS |-> m_tlast)
    else $error("window size update not last");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_NAWS) ? (m_tdata[7:0] == 8'd0)
                                         : (m_tdata[39:8] == 32'd0))
    else $error("unused result fields not zero");

endmodule

bind telnet_receive_command_stripper_core tncs_checker u_tncs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: tb/telnet_receive_command_stripper_checker.sv
`timescale 1ns / 100ps
// Checker for the telnet receive command stripper: watches both stream
// channels, predicts the results of each request and compares them.
// Depends on tncs_pkg for the command codes, phases and result width.
module telnet_receive_command_stripper_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  input  logic                          s_tlast,   // end_of_segment
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [tncs_pkg::RESULT_W-1:0] m_tdata,   // [7:0] data_byte, [23:8] columns,
                                                   // [39:24] rows
  input  logic                          m_tuser,   // kind
  input  logic                          m_tlast,   // last result of its request
  output int                            error_count,
  output int                            outstanding
);
  import tncs_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] columns;
    logic [15:0] rows;
    logic        last;
  } strip_result_t;

  strip_result_t expected_q[$];
  strip_result_t want;
  strip_result_t seen;
  int            fails = 0;
  int            queued = 0;

  // Own copy of the parser state
  phase_t        phase = PH_TEXT;
  logic [2:0]    sn_count = '0;
  logic [7:0]    sn_option = '0;
  logic [15:0]   width_acc = '0;
  logic [15:0]   height_acc = '0;

  assign error_count = fails;
  assign outstanding = queued;

  function void emit(input logic kind, input logic [7:0] data,
                     input logic [15:0] cols, input logic [15:0] rows);
    strip_result_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.columns   = cols;
    r.rows      = rows;
    r.last      = 1'b0;
    expected_q.push_back(r);
  endfunction

  function void plain_text(input logic [7:0] b);
    if (b == CMD_IAC) begin
      phase = PH_IAC;
    end else if (b == CH_CR) begin
      phase = PH_CR;
    end else begin
      phase = PH_TEXT;
      emit(KIND_DATA, b, 16'd0, 16'd0);
    end
  endfunction

  // Option byte first, then width and height, high byte first
  function void take_subneg(input logic [7:0] b);
    case (sn_count)
      3'd0: sn_option = b;
      3'd1: width_acc[15:8] = b;
      3'd2: width_acc[7:0] = b;
      3'd3: height_acc[15:8] = b;
      3'd4: height_acc[7:0] = b;
      default: ;
    endcase
    if (sn_count < SUBNEG_MAX) sn_count = sn_count + 3'd1;
  endfunction

  function void strip_byte(input logic [7:0] b, input logic seg_end);
    int n_prior;
    n_prior = expected_q.size();
    case (phase)
      PH_CR: begin
        if (b == CH_NUL) begin
          phase = PH_TEXT;
          emit(KIND_DATA, CH_CR, 16'd0, 16'd0);
        end else if (b == CH_LF) begin
          phase = PH_TEXT;
          emit(KIND_DATA, CH_LF, 16'd0, 16'd0);
        end else begin
          emit(KIND_DATA, CH_LF, 16'd0, 16'd0);
          plain_text(b);
        end
      end
      PH_IAC: begin
        if (b == CMD_IAC) begin
          phase = PH_TEXT;
          emit(KIND_DATA, LIT_FF, 16'd0, 16'd0);
        end else if (b >= CMD_WILL && b <= CMD_DONT) begin
          phase = PH_OPT;
        end else if (b == CMD_SB) begin
          phase      = PH_SUB;
          sn_count   = '0;
          sn_option  = '0;
          width_acc  = '0;
          height_acc = '0;
        end else begin
          phase = PH_TEXT;
        end
      end
      PH_OPT: phase = PH_TEXT;
      PH_SUB: begin
        if (b == CMD_IAC) phase = PH_SUBIAC;
        else take_subneg(b);
      end
      PH_SUBIAC: begin
        if (b == CMD_SE) begin
          phase = PH_TEXT;
          if (sn_option == OPT_NAWS && sn_count >= SUBNEG_NAWS)
            emit(KIND_NAWS, 8'd0, width_acc, height_acc);
        end else begin
          phase = PH_SUB;
          take_subneg(b);
        end
      end
      default: plain_text(b);
    endcase
    // segment end flushes a held CR and abandons any open command
    if (seg_end) begin
      if (phase == PH_CR) emit(KIND_DATA, CH_LF, 16'd0, 16'd0);
      phase = PH_TEXT;
    end
    if (expected_q.size() > n_prior) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function void compare_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      fails++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_TEXT;
      sn_count   = '0;
      sn_option  = '0;
      width_acc  = '0;
      height_acc = '0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) strip_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24], m_tlast};
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, got kind %0d tdata %h last %0d",
                   $time, m_tuser, m_tdata, m_tlast);
        end else begin
          want = expected_q.pop_front();
          compare_field("kind", 16'(want.kind), 16'(seen.kind));
          compare_field("data_byte", 16'(want.data_byte), 16'(seen.data_byte));
          compare_field("columns", want.columns, seen.columns);
          compare_field("rows", want.rows, seen.rows);
          compare_field("last", 16'(want.last), 16'(seen.last));
        end
      end
    end
    queued = expected_q.size();
  end

endmodule

FILE: tb/telnet_receive_command_stripper_core_tb.sv
`timescale 1ns / 100ps
// Top of the stripper testbench: clock, reset, byte stream and ready pattern.
// Depends on tncs_pkg, the core and telnet_receive_command_stripper_checker.
module telnet_receive_command_stripper_core_tb;
  import tncs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 870;

  typedef struct packed {
    logic [7:0] value;
    logic       seg_end;
  } rx_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // [7:0] in_byte
  logic                s_tlast = 1'b0; // end_of_segment
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;        // [7:0] data_byte, [23:8] columns, [39:24] rows
  logic                m_tuser;        // kind
  logic                m_tlast;

  int                  error_count;
  int                  outstanding;
  int                  cycle_count = 0;

  rx_byte_t            rx_stream[$];

  // receiver stall pattern state
  int                  stall_mode = 0;
  int                  mode_left = 0;
  logic [7:0]          ready_pattern = 8'hff;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  telnet_receive_command_stripper_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  telnet_receive_command_stripper_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // Receiver: switches between free flow, coin toss, a rotating mask and a
  // slow drip, each held for a random stretch of cycles.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode    = $urandom_range(0, 3);
      mode_left     = $urandom_range(16, 80);
      ready_pattern = 8'($urandom_range(1, 255));
    end
    mode_left--;
    ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ready_pattern[0];
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function void push_rx(input logic [7:0] b, input logic seg_end);
    rx_byte_t r;
    r.value   = b;
    r.seg_end = seg_end;
    rx_stream.push_back(r);
  endfunction

  // Given byte with an occasional segment end dropped in
  function void push_rnd_end(input logic [7:0] b);
    push_rx(b, $urandom_range(0, 39) == 0);
  endfunction

  function logic [7:0] value_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed phrases with random content, plus some noise
  task build_random_stream();
    int target;
    int n;
    logic [7:0] v;
    target = rx_stream.size() + RANDOM_BYTES;
    while (rx_stream.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) push_rnd_end(8'($urandom_range(0, 255)));
        3: begin
          push_rnd_end(CH_CR);
          case ($urandom_range(0, 2))
            0:       push_rnd_end(CH_NUL);
            1:       push_rnd_end(CH_LF);
            default: push_rnd_end(8'($urandom_range(0, 255)));
          endcase
        end
        4: begin
          push_rnd_end(CMD_IAC);
          push_rnd_end(CMD_IAC);
        end
        5: begin
          push_rnd_end(CMD_IAC);
          push_rnd_end(8'($urandom_range(CMD_WILL, CMD_DONT)));
          push_rnd_end(8'($urandom_range(0, 255)));
        end
        6: begin
          push_rnd_end(CMD_IAC);
          push_rnd_end(8'($urandom_range(0, 1) ? $urandom_range(CMD_SE, CMD_SB - 1)
                                                : $urandom_range(0, 255)));
        end
        7, 8: begin
          push_rnd_end(CMD_IAC);
          push_rnd_end(CMD_SB);
          push_rnd_end(($urandom_range(0, 3) == 0) ? value_byte() : OPT_NAWS);
          n = $urandom_range(0, 1) ? 4 : $urandom_range(0, 7);
          repeat (n) begin
            v = value_byte();
            if (v == CMD_IAC) begin
              push_rnd_end(CMD_IAC);
              push_rnd_end(CMD_IAC);
            end else if ($urandom_range(0, 9) == 0 && v != CMD_SE) begin
              // stray IAC before an ordinary byte inside the subnegotiation
              push_rnd_end(CMD_IAC);
              push_rnd_end(v);
            end else begin
              push_rnd_end(v);
            end
          end
          if ($urandom_range(0, 7) != 0) begin
            push_rnd_end(CMD_IAC);
            push_rnd_end(CMD_SE);
          end
        end
        default: push_rx(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endtask

  task send_byte(input rx_byte_t r);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= r.value;
    s_tlast  <= r.seg_end;
    do @(posedge clk); while (!s_tready);
  endtask

  task idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  initial begin
    int burst_left;

    // Directed opening: extremes, every line-end case, each command form
    push_rx(8'h41, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(CH_CR, 1'b0);  push_rx(CH_NUL, 1'b0);                   // CR NUL -> CR
    push_rx(CH_CR, 1'b0);  push_rx(CH_LF, 1'b0);                    // CR LF -> LF
    push_rx(CH_CR, 1'b0);  push_rx(8'h62, 1'b0);                    // bare CR, two results
    push_rx(CMD_IAC, 1'b0); push_rx(CMD_IAC, 1'b0);                 // escaped 0xff
    push_rx(CMD_IAC, 1'b0); push_rx(CMD_WILL, 1'b0); push_rx(8'h01, 1'b0);
    push_rx(CMD_IAC, 1'b0); push_rx(8'hf1, 1'b0);                   // two-byte command
    // window size 0x00ff x 0x0102, with an escaped 0xff among the values
    push_rx(CMD_IAC, 1'b0); push_rx(CMD_SB, 1'b0); push_rx(OPT_NAWS, 1'b0);
    push_rx(8'h00, 1'b0);   push_rx(CMD_IAC, 1'b0); push_rx(CMD_IAC, 1'b0);
    push_rx(8'h01, 1'b0);   push_rx(8'h02, 1'b0);
    push_rx(CMD_IAC, 1'b0); push_rx(CMD_SE, 1'b0);
    push_rx(CH_CR, 1'b1);                                           // CR flushed at segment end
    build_random_stream();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    burst_left = 0;
    foreach (rx_stream[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
      end
      send_byte(rx_stream[i]);
      burst_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then watch for anything stray
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
